[design/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/nsfc_pkg.sv]
`timescale 1ns / 1ps

package nsfc_pkg;

    // buffer and length limits
    localparam int BUFFER_BYTES = 128;
    localparam int MIN_LENGTH   = 9;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES);

    // field widths
    localparam int CMD_W     = 1;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 7;
    localparam int CSUM_W    = 8;
    localparam int TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BYTE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

    // framing characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // ascii hex digit to nibble, upper and lower case letters
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.val = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[design/nsfc_in_if.sv]
`timescale 1ns / 1ps

interface nsfc_in_if;
    import nsfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, command, byte_value, input ready);
    modport sink   (input valid, command, byte_value, output ready);
endinterface

[design/nsfc_out_if.sv]
`timescale 1ns / 1ps

interface nsfc_out_if;
    import nsfc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    sentence_length;
    logic [CSUM_W-1:0]   computed_checksum;
    logic [CSUM_W-1:0]   received_checksum;

    modport source (output valid, status, sentence_length, computed_checksum,
                    received_checksum, input ready);
    modport sink   (input valid, status, sentence_length, computed_checksum,
                    received_checksum, output ready);
endinterface

[design/nmea_sentence_framer_checker_top.sv]
`timescale 1ns / 1ps
// the item that closes a sentence passes through the input register, then its result is held in the result register
// throughput: one item per cycle while the result is not stalled, set by the input register feeding the result register
// a stalled result holds the input register, so at most two items wait inside the block
// reset: synchronous, active low; clears the framing state and loads the timeout with 1000
module nmea_sentence_framer_checker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    nsfc_in_if.sink                            i_in,
    nsfc_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [nsfc_pkg::TIMEOUT_W-1:0]     i_cfg_wdata
);
    import nsfc_pkg::*;

    // input register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_byte;

    // framing state
    logic                 r_in_sentence, n_in_sentence;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [CSUM_W-1:0]    r_xor, n_xor;
    logic [BYTE_W-1:0]    r_recent [3];
    logic [BYTE_W-1:0]    n_recent [3];
    logic [TIMEOUT_W-1:0] r_elapsed, n_elapsed;
    logic [TIMEOUT_W-1:0] r_timeout;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CSUM_W-1:0]   r_calc, n_calc;
    logic [CSUM_W-1:0]   r_rx, n_rx;

    logic advance;
    logic work;
    t_hex hex_hi, hex_lo;

    assign advance    = !r_out_valid || o_res.ready;
    assign work       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign hex_hi = hex_decode(r_recent[1]);
    assign hex_lo = hex_decode(r_recent[2]);

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd  <= i_in.command;
            r_byte <= i_in.byte_value;
        end
    end

    // framing and checksum step
    always_comb begin
        n_in_sentence = r_in_sentence;
        n_count       = r_count;
        n_xor         = r_xor;
        n_recent      = r_recent;
        n_elapsed     = r_elapsed;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_status      = r_status;
        n_len         = r_len;
        n_calc        = r_calc;
        n_rx          = r_rx;

        if (work) begin
            if (r_cmd == CMD_TICK) begin
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else if (!r_in_sentence) begin
                // hunting: only a dollar opens a sentence
                if (r_byte == CH_DOLLAR) begin
                    n_in_sentence = 1'b1;
                    n_count       = COUNT_W'(1);
                    n_xor         = '0;
                    n_recent[0]   = '0;
                    n_recent[1]   = '0;
                    n_recent[2]   = r_byte;
                    n_elapsed     = '0;
                end
            end else if (r_elapsed > r_timeout) begin
                // late byte aborts the sentence
                n_in_sentence = 1'b0;
                n_count       = '0;
            end else if (r_byte != CH_CR && r_byte != CH_LF) begin
                // store into the window, older bytes fold into the xor
                if (r_count < COUNT_W'(BUFFER_BYTES - 1)) begin
                    if (r_count >= COUNT_W'(4)) begin
                        n_xor = r_xor ^ r_recent[0];
                    end
                    n_recent[0] = r_recent[1];
                    n_recent[1] = r_recent[2];
                    n_recent[2] = r_byte;
                    n_count     = r_count + 1'b1;
                end
            end else begin
                // end of line: report
                n_in_sentence = 1'b0;
                n_out_valid   = 1'b1;
                n_len         = LEN_W'(r_count);
                n_calc        = r_xor;
                n_rx          = '0;
                if (r_count < COUNT_W'(MIN_LENGTH)) begin
                    n_status = ST_SHORT;
                end else if (!(hex_hi.ok && hex_lo.ok)) begin
                    n_status = ST_BAD_HEX;
                end else begin
                    n_rx     = {hex_hi.val, hex_lo.val};
                    n_status = ({hex_hi.val, hex_lo.val} == r_xor) ? ST_GOOD : ST_MISMATCH;
                end
            end
        end
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_count       <= '0;
            r_xor         <= '0;
            r_recent[0]   <= '0;
            r_recent[1]   <= '0;
            r_recent[2]   <= '0;
            r_elapsed     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_count       <= n_count;
            r_xor         <= n_xor;
            r_recent      <= n_recent;
            r_elapsed     <= n_elapsed;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_len    <= n_len;
        r_calc   <= n_calc;
        r_rx     <= n_rx;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.status            = r_status;
    assign o_res.sentence_length   = r_len;
    assign o_res.computed_checksum = r_calc;
    assign o_res.received_checksum = r_rx;

endmodule

[design/nsfc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsfc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [nsfc_pkg::STATUS_W-1:0]   i_status,
    input logic [nsfc_pkg::LEN_W-1:0]      i_len,
    input logic [nsfc_pkg::CSUM_W-1:0]     i_calc,
    input logic [nsfc_pkg::CSUM_W-1:0]     i_rx
);
    import nsfc_pkg::*;

    // a stalled result holds its status and length
    `ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_status) && $stable(i_len))

    // a new result only follows an accepted item that passed through the input and result registers
    `ASSERT_IMP(a_res_cause, i_clk, i_rst_n, $rose(i_res_valid), $past(i_in_valid && i_in_ready, 2))

    // the input side never stalls while the result side is empty
    `ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !i_res_valid, i_in_ready)

    // a good status means the checksums agree and the sentence is long enough
    `ASSERT_IMP(a_good_match, i_clk, i_rst_n, i_res_valid && i_status == ST_GOOD, i_calc == i_rx && i_len >= LEN_W'(MIN_LENGTH))

    // a short sentence carries no decoded checksum
    `ASSERT_IMP(a_short_rx, i_clk, i_rst_n, i_res_valid && i_status == ST_SHORT, i_rx == '0 && i_len < LEN_W'(MIN_LENGTH))

endmodule

bind nmea_sentence_framer_checker_top nsfc_checker u_nsfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_len       (o_res.sentence_length),
    .i_calc      (o_res.computed_checksum),
    .i_rx        (o_res.received_checksum)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import nsfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 80;
    localparam logic [BYTE_W-1:0] ASTERISK = 8'h2A;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_HEX} t_frame_kind;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
        logic [CSUM_W-1:0]   calc_sum;
        logic [CSUM_W-1:0]   rcvd_sum;
    } t_sentence_report;

    // sentence framing predictor and queue of expected status reports
    class sentence_scoreboard;
        logic [TIMEOUT_W-1:0] timeout_ms;
        bit                   in_sentence;
        int                   stored;
        logic [CSUM_W-1:0]    xor_sum;
        logic [BYTE_W-1:0]    window [3];
        logic [15:0]          elapsed;
        t_sentence_report     expected_q[$];
        int                   errors;

        function new();
            timeout_ms  = TIMEOUT_RESET;
            in_sentence = 1'b0;
            stored      = 0;
            xor_sum     = '0;
            window      = '{default: '0};
            elapsed     = '0;
            errors      = 0;
        endfunction

        function void set_timeout(logic [TIMEOUT_W-1:0] value);
            timeout_ms = value;
        endfunction

        // bytes leaving the three-byte window join the checksum, index 0 never does
        function void store(logic [BYTE_W-1:0] b);
            if (stored >= BUFFER_BYTES - 1) return;
            if (stored >= 4) xor_sum ^= window[0];
            window[0] = window[1];
            window[1] = window[2];
            window[2] = b;
            stored++;
        endfunction

        function int nibble(logic [BYTE_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
            return -1;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
            t_sentence_report r;
            int hi;
            int lo;
            if (cmd == CMD_TICK) begin
                if (elapsed != 16'hFFFF) elapsed++;
                return;
            end
            // hunting: only a dollar opens a sentence
            if (!in_sentence) begin
                if (b != CH_DOLLAR) return;
                in_sentence = 1'b1;
                stored      = 0;
                xor_sum     = '0;
                window      = '{default: '0};
                elapsed     = '0;
                store(b);
                return;
            end
            // late byte abandons the sentence and is dropped
            if (elapsed > timeout_ms) begin
                in_sentence = 1'b0;
                stored      = 0;
                return;
            end
            if (b != CH_CR && b != CH_LF) begin
                store(b);
                return;
            end
            // end of line closes the sentence
            in_sentence = 1'b0;
            r.len      = LEN_W'(stored);
            r.calc_sum = xor_sum;
            r.rcvd_sum = '0;
            if (stored < MIN_LENGTH) begin
                r.status = ST_SHORT;
            end else begin
                hi = nibble(window[1]);
                lo = nibble(window[2]);
                if (hi < 0 || lo < 0) begin
                    r.status = ST_BAD_HEX;
                end else begin
                    r.rcvd_sum = CSUM_W'(hi * 16 + lo);
                    r.status   = (r.rcvd_sum == xor_sum) ? ST_GOOD : ST_MISMATCH;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_sentence_report got);
            t_sentence_report want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: status %0d len %0d calc %02h rcvd %02h",
                             got.status, got.len, got.calc_sum, got.rcvd_sum);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.len !== want.len ||
                got.calc_sum !== want.calc_sum || got.rcvd_sum !== want.rcvd_sum) begin
                errors++;
                if (errors <= 10)
                    $display("report mismatch: expected status %0d len %0d calc %02h rcvd %02h,",
                             want.status, want.len, want.calc_sum, want.rcvd_sum,
                             " got status %0d len %0d calc %02h rcvd %02h",
                             got.status, got.len, got.calc_sum, got.rcvd_sum);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TIMEOUT_W-1:0] i_cfg_wdata;

    nsfc_in_if  in_if ();
    nsfc_out_if res_if ();

    sentence_scoreboard sb = new();

    bit gaps_on;
    int hold_left;
    int items_sent;
    int idle_cycles;

    nmea_sentence_framer_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: random stalls plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = !(gaps_on && $urandom_range(99) < 14);
            end
        end
    end

    // monitor: register writes, accepted items, reports and watchdog
    always @(posedge i_clk) begin
        t_sentence_report got;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_we) sb.set_timeout(i_cfg_wdata);
            if (in_if.valid && in_if.ready) begin
                sb.note_item(in_if.command, in_if.byte_value);
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                got.status   = res_if.status;
                got.len      = res_if.sentence_length;
                got.calc_sum = res_if.computed_checksum;
                got.rcvd_sum = res_if.received_checksum;
                sb.check_result(got);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 14) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.command    = cmd;
        in_if.byte_value = value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[i]) send_item(CMD_BYTE, q[i]);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(CMD_TICK, BYTE_W'($urandom));
    endtask

    function automatic t_byte_q text_bytes(string s);
        t_byte_q q;
        q = {};
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // mostly printable payload, now and then any byte but an end of line
    function automatic t_byte_q random_body(int len);
        t_byte_q q;
        logic [BYTE_W-1:0] b;
        q = {};
        repeat (len) begin
            if ($urandom_range(9) == 0) begin
                do b = BYTE_W'($urandom); while (b == CH_CR || b == CH_LF);
            end else begin
                b = BYTE_W'($urandom_range(8'h7E, 8'h20));
            end
            q.push_back(b);
        end
        return q;
    endfunction

    function automatic logic [BYTE_W-1:0] ascii_hex(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return (($urandom_range(1) != 0) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom);
        while (b == CH_CR || b == CH_LF || (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66));
        return b;
    endfunction

    // dollar, payload, star, two checksum digits and an end of line
    task automatic send_sentence(input t_byte_q body, input t_frame_kind kind,
                                 input int tick_pct);
        t_byte_q frame;
        logic [CSUM_W-1:0] sum;
        int pick;
        sum = '0;
        foreach (body[i]) sum ^= body[i];
        if (kind == FRAME_BAD_SUM) sum ^= CSUM_W'($urandom_range(255, 1));
        frame = {CH_DOLLAR};
        frame = {frame, body};
        frame.push_back(ASTERISK);
        frame.push_back(ascii_hex(sum[7:4]));
        frame.push_back(ascii_hex(sum[3:0]));
        if (kind == FRAME_BAD_HEX) begin
            pick = $urandom_range(2);
            if (pick != 1) frame[frame.size()-2] = non_hex_byte();
            if (pick != 0) frame[frame.size()-1] = non_hex_byte();
        end
        frame.push_back(($urandom_range(1) != 0) ? CH_CR : CH_LF);
        foreach (frame[i]) begin
            if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(3, 1));
            send_item(CMD_BYTE, frame[i]);
        end
    endtask

    // let every expected report and any item still in flight come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // one random stretch of sentences, fragments, noise and tick bursts
    task automatic random_phase(input int n_items);
        int phase_end;
        int r;
        int tick_pct;
        t_frame_kind kind;
        phase_end = items_sent + n_items;
        while (items_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 65) begin
                r = $urandom_range(99);
                kind = (r < 60) ? FRAME_GOOD : (r < 80) ? FRAME_BAD_SUM : FRAME_BAD_HEX;
                r = $urandom_range(2);
                tick_pct = (r == 0) ? 0 : (r == 1) ? 5 : 20;
                send_sentence(random_body(($urandom_range(99) < 5) ?
                              $urandom_range(135, 110) : $urandom_range(20, 0)),
                              kind, tick_pct);
            end else if (r < 75) begin
                send_item(CMD_BYTE, CH_DOLLAR);
                send_bytes(random_body($urandom_range(12, 0)));
            end else if (r < 85) begin
                repeat ($urandom_range(6, 1)) send_item(CMD_BYTE, BYTE_W'($urandom));
            end else begin
                send_ticks(($urandom_range(9) == 0) ? $urandom_range(60, 9) :
                           $urandom_range(8, 1));
            end
        end
    endtask

    initial begin
        logic [TIMEOUT_W-1:0] phase_timeout [6];
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.command    = CMD_BYTE;
        in_if.byte_value = '0;
        gaps_on          = 1'b1;
        hold_left        = 0;
        items_sent       = 0;
        idle_cycles      = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // bytes while hunting are ignored, end of line included
        send_item(CMD_BYTE, 8'h41);
        send_item(CMD_BYTE, CH_CR);
        send_item(CMD_BYTE, CH_LF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_TICK, 8'hA5);

        // one short of the minimum length, then exactly the minimum
        send_sentence(text_bytes("GPRM"), FRAME_GOOD, 0);
        send_sentence(text_bytes("GPRMC"), FRAME_GOOD, 0);
        send_sentence(text_bytes("GPGGA,12"), FRAME_BAD_SUM, 0);
        send_sentence(text_bytes("GPGSV,3"), FRAME_BAD_HEX, 0);
        // dollar inside a sentence is stored, not a restart
        send_sentence(text_bytes("AB$CD$E"), FRAME_GOOD, 0);
        send_sentence({8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA}, FRAME_GOOD, 0);
        send_bytes({CH_DOLLAR, CH_LF});
        // buffer overflow drops the tail
        send_sentence(random_body(130), FRAME_GOOD, 0);

        // short timeout: exactly at the limit is still fine
        write_timeout(16'd3);
        send_item(CMD_BYTE, CH_DOLLAR);
        send_ticks(3);
        send_bytes({8'h5A, CH_CR});
        // one tick past it the end of line is dropped, the next one ignored
        send_item(CMD_BYTE, CH_DOLLAR);
        send_ticks(4);
        send_bytes({CH_CR, CH_LF});

        // long result stall while short sentences keep coming
        hold_left = HOLD_CYCLES;
        repeat (8) send_bytes({CH_DOLLAR, CH_CR});

        // zero timeout: any tick aborts the sentence
        write_timeout('0);
        send_bytes({CH_DOLLAR, 8'h41, CH_CR});
        send_item(CMD_BYTE, CH_DOLLAR);
        send_ticks(1);
        send_bytes({CH_CR, CH_LF});

        // maximum timeout does not expire
        write_timeout(16'hFFFF);
        send_item(CMD_BYTE, CH_DOLLAR);
        send_ticks(20);
        send_bytes({8'h41, CH_CR});

        // random phases over several timeouts, one without any gaps
        phase_timeout = '{16'd3, 16'd40, 16'd0, TIMEOUT_RESET,
                          TIMEOUT_W'($urandom), 16'hFFFF};
        foreach (phase_timeout[i]) begin
            write_timeout(phase_timeout[i]);
            gaps_on = (i != 1);
            random_phase(PHASE_ITEMS);
        end
        gaps_on = 1'b1;

        wait_drained();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[nmea_sentence_framer_checker_top.f]
+incdir+design
design/nsfc_pkg.sv
design/nsfc_in_if.sv
design/nsfc_out_if.sv
design/nmea_sentence_framer_checker_top.sv
design/nsfc_checker.sv
test/tb_top.sv
